@@ design/trd_pkg.sv @@
// Shared types and constants for the run-length pixel decoder.
// No dependencies; the other design files except trd_fifo refer to it by scoped names.
package trd_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_FOUR_BYTE_PIXELS = 3'd0,
    CFG_RLE_MODE         = 3'd1,
    CFG_TOP_ORIGIN       = 3'd2,
    CFG_IMAGE_WIDTH      = 3'd3,
    CFG_IMAGE_HEIGHT     = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [31:0] PIXEL_INIT  = 32'hFF00_0000;
  localparam logic [6:0]  HDR_COUNT_MASK = 7'h7F;

  typedef struct packed {
    logic        four_byte_pixels;
    logic        rle_mode;
    logic        top_origin;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [15:0] dest_row;
    logic [15:0] dest_col;
    logic [7:0]  seg_count;
    logic        last_of_run;
    logic        image_done;
  } out_word_t;

  // Command passed from front to back: optional position clear and a run
  typedef struct packed {
    logic        clear;
    logic        has_pix;
    logic [31:0] colour;
    logic [7:0]  count;
  } cmd_t;

  // Back-end state machine
  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } bk_state_e;

endpackage

@@ design/trd_fifo.sv @@
// Small register FIFO decoupling front and back of the decoder.
// Generic: width and depth parameters only; no package use.
module trd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/trd_front.sv @@
// Front end: packet headers, pixel byte assembly and run commands.
// Depends on trd_pkg; feeds trd_fifo with cmd_t words.
module trd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  trd_pkg::cfg_t   cfg_i,
  input  logic            take_i,
  input  trd_pkg::in_word_t word_i,
  output logic            push_o,
  output trd_pkg::cmd_t   cmd_o
);

  logic [7:0]  left_q, left_d;
  logic        rpt_q, rpt_d;
  logic [1:0]  bip_q, bip_d;
  logic [31:0] asm_q, asm_d;

  always_comb begin
    logic [7:0]  left_b;
    logic        rpt_b;
    logic [1:0]  bip_b, bip_n;
    logic [31:0] asm_b;
    logic        pix_done;

    // a start-of-image word clears packet state before its byte is used
    left_b = word_i.start_of_image ? '0 : left_q;
    rpt_b  = word_i.start_of_image ? 1'b0 : rpt_q;
    bip_b  = word_i.start_of_image ? '0 : bip_q;
    asm_b  = word_i.start_of_image ? trd_pkg::PIXEL_INIT : asm_q;
    bip_n  = bip_b + 2'd1;

    left_d = left_q;
    rpt_d  = rpt_q;
    bip_d  = bip_q;
    asm_d  = asm_q;
    pix_done = 1'b0;

    cmd_o.clear   = word_i.start_of_image;
    cmd_o.has_pix = 1'b0;
    cmd_o.colour  = asm_b;
    cmd_o.count   = 8'd1;

    if (cfg_i.rle_mode && left_b == '0) begin
      left_d = {1'b0, word_i.data_byte[6:0] & trd_pkg::HDR_COUNT_MASK} + 8'd1;
      rpt_d  = word_i.data_byte[7];
      bip_d  = bip_b;
      asm_d  = asm_b;
    end else begin
      asm_b[8*bip_b +: 8] = word_i.data_byte;
      cmd_o.colour = asm_b;
      // size may have changed mid-pixel: done once the count reaches it
      pix_done = (bip_n == 2'd0) || (!cfg_i.four_byte_pixels && bip_n == 2'd3);
      left_d = left_b;
      rpt_d  = rpt_b;
      if (pix_done) begin
        bip_d = '0;
        asm_d = trd_pkg::PIXEL_INIT;
        cmd_o.has_pix = 1'b1;
        if (cfg_i.rle_mode) begin
          if (rpt_b) begin
            cmd_o.count = left_b;
            left_d = '0;
          end else begin
            left_d = left_b - 8'd1;
          end
        end
      end else begin
        bip_d = bip_n;
        asm_d = asm_b;
      end
    end

    push_o = take_i && (word_i.start_of_image || pix_done);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      rpt_q  <= 1'b0;
      bip_q  <= '0;
      asm_q  <= trd_pkg::PIXEL_INIT;
    end else if (take_i) begin
      left_q <= left_d;
      rpt_q  <= rpt_d;
      bip_q  <= bip_d;
      asm_q  <= asm_d;
    end
  end

endmodule

@@ design/trd_back.sv @@
// Back end: places runs on the image, one row segment per cycle while the output register is free.
// Depends on trd_pkg; takes cmd_t words from trd_fifo, drives the output register.
module trd_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trd_pkg::cfg_t      cfg_i,
  input  logic               cmd_avail_i,
  input  trd_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output trd_pkg::out_word_t out_word_o
);

  localparam int unsigned Cb = COORD_BITS;
  localparam logic [16:0] CoordMax = 17'((1 << COORD_BITS) - 1);

  trd_pkg::bk_state_e state_q, state_d;
  logic [Cb-1:0] col_q, col_d, row_q, row_d;
  logic          done_q, done_d;
  logic [7:0]    n_q, n_d;
  logic [31:0]   colour_q, colour_d;
  logic          ovld_q, ovld_d;
  trd_pkg::out_word_t oword_q, oword_d;

  logic [Cb-1:0] w_eff, h_eff;
  logic          out_free;

  // effective size: width at least 4, height at least 1, both saturated
  always_comb begin
    if ({1'b0, cfg_i.image_width} > CoordMax) begin
      w_eff = '1;
    end else if (cfg_i.image_width < 16'd4) begin
      w_eff = Cb'(4);
    end else begin
      w_eff = cfg_i.image_width[Cb-1:0];
    end
    if ({1'b0, cfg_i.image_height} > CoordMax) begin
      h_eff = '1;
    end else if (cfg_i.image_height == 16'd0) begin
      h_eff = Cb'(1);
    end else begin
      h_eff = cfg_i.image_height[Cb-1:0];
    end
  end

  assign out_free = !ovld_q || !out_stall_i;

  always_comb begin
    logic [Cb-1:0] cb, rb, c1, r1, room, seg_w, col_sum, row_inc;
    logic          db, d1, row_wrap, done_new;
    logic [7:0]    n_next;

    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    done_d   = done_q;
    n_d      = n_q;
    colour_d = colour_q;
    ovld_d   = ovld_q && out_stall_i;
    oword_d  = oword_q;
    pop_o    = 1'b0;

    cb = cmd_i.clear ? '0 : col_q;
    rb = cmd_i.clear ? '0 : row_q;
    db = cmd_i.clear ? 1'b0 : done_q;
    if (cb >= w_eff) begin
      c1 = '0;
      r1 = rb + 1'b1;
    end else begin
      c1 = cb;
      r1 = rb;
    end
    d1 = (r1 >= h_eff);

    room     = w_eff - col_q;
    seg_w    = (Cb'(n_q) < room) ? Cb'(n_q) : room;
    n_next   = n_q - seg_w[7:0];
    col_sum  = col_q + seg_w;
    row_wrap = (col_sum >= w_eff);
    row_inc  = row_q + 1'b1;
    done_new = row_wrap && (row_inc >= h_eff);

    unique case (state_q)
      trd_pkg::BK_IDLE: begin
        if (cmd_avail_i) begin
          pop_o = 1'b1;
          col_d = cb;
          row_d = rb;
          done_d = db;
          // pixels past the end are dropped without a word
          if (cmd_i.has_pix && !db) begin
            col_d    = c1;
            row_d    = r1;
            done_d   = d1;
            n_d      = cmd_i.count;
            colour_d = cmd_i.colour;
            if (!d1) begin
              state_d = trd_pkg::BK_RUN;
            end
          end
        end
      end
      trd_pkg::BK_RUN: begin
        if (out_free) begin
          ovld_d = 1'b1;
          oword_d.pixel_color = colour_q;
          oword_d.dest_row    = cfg_i.top_origin ? 16'(row_q)
                                                 : 16'(h_eff - 1'b1 - row_q);
          oword_d.dest_col    = 16'(col_q);
          oword_d.seg_count   = seg_w[7:0];
          oword_d.last_of_run = (n_next == 8'd0) || done_new;
          oword_d.image_done  = done_new;
          n_d = n_next;
          if (row_wrap) begin
            col_d  = '0;
            row_d  = row_inc;
            done_d = done_new;
          end else begin
            col_d = col_sum;
          end
          if (n_next == 8'd0 || done_new) begin
            state_d = trd_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = trd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trd_pkg::BK_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      done_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      done_q  <= done_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    colour_q <= colour_d;
    oword_q  <= oword_d;
  end

  assign out_valid_o = ovld_q;
  assign out_word_o  = oword_q;

endmodule

@@ design/tga_rle_pixel_decoder.sv @@
// Top level of the run-length pixel decoder: config registers, front, queue, back.
// Depends on trd_pkg, trd_front, trd_fifo and trd_back.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------
//   in      | in_valid_i / in_stall_o   | in_word_i  (trd_pkg::in_word_t)
//   out     | out_valid_o / out_stall_i | out_word_o (trd_pkg::out_word_t)
//   cfg     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// The front takes one byte per cycle while the queue has room.
// Each pixel run is loaded by the back in BK_IDLE, then written out in BK_RUN as row segments
// (up to 33 segments for a run of 128); the queue lets bytes flow meanwhile.
// Reset is asynchronous and needs no clearing pass.
// out_stall_i holds the output register; in_stall_o rises while the queue is full.
module tga_rle_pixel_decoder #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  trd_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output trd_pkg::out_word_t                out_word_o,
  input  logic                              cfg_we_i,
  input  logic [trd_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [trd_pkg::CfgDataBits-1:0]   cfg_wdata_i
);

  trd_pkg::cfg_t cfg_q;
  trd_pkg::cmd_t push_cmd, pop_cmd;
  logic take, push, pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.four_byte_pixels <= 1'b0;
      cfg_q.rle_mode         <= 1'b1;
      cfg_q.top_origin       <= 1'b0;
      cfg_q.image_width      <= 16'd4;
      cfg_q.image_height     <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (trd_pkg::cfg_idx_e'(cfg_idx_i))
        trd_pkg::CFG_FOUR_BYTE_PIXELS: cfg_q.four_byte_pixels <= cfg_wdata_i[0];
        trd_pkg::CFG_RLE_MODE:         cfg_q.rle_mode         <= cfg_wdata_i[0];
        trd_pkg::CFG_TOP_ORIGIN:       cfg_q.top_origin       <= cfg_wdata_i[0];
        trd_pkg::CFG_IMAGE_WIDTH:      cfg_q.image_width      <= cfg_wdata_i;
        trd_pkg::CFG_IMAGE_HEIGHT:     cfg_q.image_height     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  trd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .take_i (take),
    .word_i (in_word_i),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  trd_fifo #(
    .Width ($bits(trd_pkg::cmd_t)),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (q_empty)
  );

  trd_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_avail_i (!q_empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // a word closing the image is always the last of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.image_done |-> out_word_o.last_of_run)
    else $error("image_done without last_of_run");

  // segments are never empty and never longer than the longest run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.seg_count != 8'd0 && out_word_o.seg_count <= 8'd128)
    else $error("bad segment length");

  // the front only pushes on a byte it has taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> take && !q_full)
    else $error("queue push without accepted word");

  // the back pops only when it has a command to take
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue pop while empty");

endmodule

@@ tb/tb_tga_rle_pixel_decoder.sv @@
// Self-checking testbench for tga_rle_pixel_decoder: a directed table, then random images.
// Depends on trd_pkg and the decoder RTL; carries its own model of the segment output.
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;

  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_BYTES   = 60;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {SINK_FREE, SINK_PATCHY, SINK_CHOKED} sink_mode_e;

  typedef struct packed {
    row_kind_e          kind;
    trd_pkg::cfg_t      cfg;
    trd_pkg::in_word_t  word;
    logic               typed;
    trd_pkg::out_word_t want;
  } dir_row_t;

  localparam trd_pkg::cfg_t      NO_CFG = '0;
  localparam trd_pkg::out_word_t NO_SEG = '0;

  // Fields: kind, config, input word, typed, typed segment
  localparam dir_row_t DIR_ROWS [31] = '{
    // reset setting: 3-byte pixels, packets, mirrored, 4 x 1; run of 128 clipped
    '{ROW_BYTE, NO_CFG, '{8'hFF, 1'b1}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h11, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h22, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h33, 1'b0}, 1'b1,
      '{32'hFF33_2211, 16'd0, 16'd0, 8'd4, 1'b1, 1'b1}},
    '{ROW_BYTE, NO_CFG, '{8'h5A, 1'b0}, 1'b0, NO_SEG},          // past the end
    // zero width and height fall back to 4 x 1; alpha byte from the stream
    '{ROW_CFG, '{1'b1, 1'b1, 1'b1, 16'd0, 16'd0}, '0, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h80, 1'b1}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h00, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h00, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h00, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h00, 1'b0}, 1'b1,
      '{32'h0000_0000, 16'd0, 16'd0, 8'd1, 1'b1, 1'b0}},
    // widest image; repeat packet, pixel left half built
    '{ROW_CFG, '{1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF}, '0, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h85, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h44, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h55, 1'b0}, 1'b0, NO_SEG},
    // pixel size drops to three mid-pixel, so the next byte completes it
    '{ROW_CFG, '{1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF}, '0, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h66, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h7F, 1'b0}, 1'b0, NO_SEG},
    // plain bytes, width shrunk below the column: wraps to the next row
    '{ROW_CFG, '{1'b0, 1'b0, 1'b0, 16'd5, 16'hFFFF}, '0, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h01, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h02, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h03, 1'b0}, 1'b0, NO_SEG},
    // back to packets: the literal packet carries on without a header
    '{ROW_CFG, '{1'b0, 1'b1, 1'b0, 16'd5, 16'd2}, '0, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h04, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h05, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h06, 1'b0}, 1'b0, NO_SEG},
    // height shrunk under the row: pixel dropped, image over
    '{ROW_CFG, '{1'b0, 1'b1, 1'b0, 16'd5, 16'd1}, '0, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h07, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h08, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h09, 1'b0}, 1'b0, NO_SEG},
    '{ROW_BYTE, NO_CFG, '{8'h0A, 1'b0}, 1'b0, NO_SEG}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid;
  logic                            in_stall_o;
  trd_pkg::in_word_t               in_word;
  logic                            out_valid_o;
  logic                            out_stall;
  trd_pkg::out_word_t              out_word_o;
  logic                            cfg_we;
  logic [trd_pkg::CfgIdxBits-1:0]  cfg_idx;
  logic [trd_pkg::CfgDataBits-1:0] cfg_wdata;

  tga_rle_pixel_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Decoder model state
  trd_pkg::cfg_t cfg_now;
  logic [7:0]    pk_left;
  logic          pk_repeat;
  logic [1:0]    byte_idx;
  logic [31:0]   asm_word;
  logic [15:0]   col_pos;
  logic [15:0]   row_pos;
  logic          img_done;

  trd_pkg::out_word_t fresh_segs[$];
  trd_pkg::out_word_t pending_segs[$];
  int unsigned        mismatches = 0;
  int unsigned        burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned eff_width();
    return (cfg_now.image_width < 16'd4) ? 4 : cfg_now.image_width;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_now.image_height == 16'd0) ? 1 : cfg_now.image_height;
  endfunction

  function automatic void clear_image_state();
    pk_left   = '0;
    pk_repeat = 1'b0;
    byte_idx  = '0;
    asm_word  = trd_pkg::PIXEL_INIT;
    col_pos   = '0;
    row_pos   = '0;
    img_done  = 1'b0;
  endfunction

  // Splits a run of n pixels into row segments, clipped at the image end
  function automatic void place_run(logic [31:0] colour, int unsigned n);
    int unsigned        w, h, seg, k;
    trd_pkg::out_word_t s;
    w = eff_width();
    h = eff_height();
    k = 0;
    if (col_pos >= w) begin
      col_pos = '0;
      row_pos = row_pos + 16'd1;
    end
    if (row_pos >= h) begin
      img_done = 1'b1;
      return;
    end
    while (n > 0 && !img_done && k < 33) begin
      seg = (n < w - col_pos) ? n : w - col_pos;
      s.pixel_color = colour;
      s.dest_row    = cfg_now.top_origin ? row_pos : 16'(h - 1 - row_pos);
      s.dest_col    = col_pos;
      s.seg_count   = 8'(seg);
      col_pos = 16'(col_pos + seg);
      n -= seg;
      if (col_pos >= w) begin
        col_pos = '0;
        row_pos = row_pos + 16'd1;
        if (row_pos >= h) img_done = 1'b1;
      end
      s.image_done = img_done;
      k++;
      s.last_of_run = !(n > 0 && !img_done && k < 33);
      fresh_segs.push_back(s);
    end
  endfunction

  // Returns 0 when the word is ignored (image already complete)
  function automatic bit decode_byte(trd_pkg::in_word_t w);
    int unsigned bpp, n;
    logic [31:0] colour;
    fresh_segs.delete();
    bpp = cfg_now.four_byte_pixels ? 4 : 3;
    if (w.start_of_image) clear_image_state();
    if (img_done) return 1'b0;
    if (cfg_now.rle_mode && pk_left == '0) begin
      pk_left   = 8'(w.data_byte & {1'b0, trd_pkg::HDR_COUNT_MASK}) + 8'd1;
      pk_repeat = w.data_byte[7];
      return 1'b1;
    end
    asm_word[8*byte_idx +: 8] = w.data_byte;
    byte_idx = byte_idx + 2'd1;
    if (byte_idx != '0 && byte_idx < bpp) return 1'b1;
    colour   = asm_word;
    byte_idx = '0;
    asm_word = trd_pkg::PIXEL_INIT;
    if (!cfg_now.rle_mode) begin
      place_run(colour, 1);
    end else if (pk_repeat) begin
      n = 32'(pk_left);
      pk_left = '0;
      place_run(colour, n);
    end else begin
      pk_left = pk_left - 8'd1;
      place_run(colour, 1);
    end
    return 1'b1;
  endfunction

  task automatic wait_drained();
    while (pending_segs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(trd_pkg::cfg_idx_e idx, logic [trd_pkg::CfgDataBits-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  // Registers change only once the decoder has gone quiet
  task automatic apply_cfg(trd_pkg::cfg_t c);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(trd_pkg::CFG_FOUR_BYTE_PIXELS, 16'(c.four_byte_pixels));
    write_reg(trd_pkg::CFG_RLE_MODE, 16'(c.rle_mode));
    write_reg(trd_pkg::CFG_TOP_ORIGIN, 16'(c.top_origin));
    write_reg(trd_pkg::CFG_IMAGE_WIDTH, c.image_width);
    write_reg(trd_pkg::CFG_IMAGE_HEIGHT, c.image_height);
    cfg_we  <= 1'b0;
    cfg_now  = c;
  endtask

  task automatic feed_byte(input trd_pkg::in_word_t w, input logic typed,
                           input trd_pkg::out_word_t want, output bit taken);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 15) == 0) wait_drained();
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    taken = decode_byte(w);
    if (typed) begin
      pending_segs.push_back(want);
    end else begin
      foreach (fresh_segs[i]) pending_segs.push_back(fresh_segs[i]);
    end
  endtask

  task automatic note_mismatch(string what, trd_pkg::out_word_t want,
                               trd_pkg::out_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: exp %h row %0d col %0d n %0d last %b done %b",
                " / got %h row %0d col %0d n %0d last %b done %b"},
               $realtime, what, want.pixel_color, want.dest_row, want.dest_col,
               want.seg_count, want.last_of_run, want.image_done, got.pixel_color,
               got.dest_row, got.dest_col, got.seg_count, got.last_of_run,
               got.image_done);
  endtask

  always @(posedge clk_i) begin : check_out
    trd_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_segs.size() == 0) begin
        note_mismatch("unexpected word", NO_SEG, out_word_o);
      end else begin
        want = pending_segs.pop_front();
        if (out_word_o.pixel_color !== want.pixel_color ||
            out_word_o.dest_row !== want.dest_row ||
            out_word_o.dest_col !== want.dest_col ||
            out_word_o.seg_count !== want.seg_count ||
            out_word_o.last_of_run !== want.last_of_run ||
            out_word_o.image_done !== want.image_done)
          note_mismatch("mismatch", want, out_word_o);
      end
    end
  end

  // Sink: switches between free flow, patchy and heavy back-pressure
  initial begin : sink
    int unsigned stall_left;
    sink_mode_e  mode;
    stall_left = 0;
    mode       = SINK_FREE;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        mode       = sink_mode_e'($urandom_range(0, 2));
        stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      case (mode)
        SINK_FREE:   out_stall <= 1'b0;
        SINK_PATCHY: out_stall <= ($urandom_range(0, 2) == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin : stimulus
    trd_pkg::cfg_t     c;
    trd_pkg::in_word_t w;
    bit                taken;
    bit                header_next;
    int unsigned       sel, done_n;
    logic [6:0]        cnt;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    cfg_now   = '{1'b0, 1'b1, 1'b0, 16'd4, 16'd1};
    clear_image_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) apply_cfg(DIR_ROWS[i].cfg);
      else feed_byte(DIR_ROWS[i].word, DIR_ROWS[i].typed, DIR_ROWS[i].want, taken);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c.four_byte_pixels = 1'($urandom_range(0, 1));
      c.rle_mode         = ($urandom_range(0, 3) != 0);
      c.top_origin       = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 9);
      c.image_width  = (sel < 7) ? 16'($urandom_range(0, 12)) :
                       (sel == 7) ? 16'($urandom_range(13, 300)) :
                       (sel == 8) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      sel = $urandom_range(0, 9);
      c.image_height = (sel < 7) ? 16'($urandom_range(0, 4)) :
                       (sel == 7) ? 16'($urandom_range(5, 40)) :
                       (sel == 8) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      apply_cfg(c);

      // The image carries on across the setting change unless restarted
      done_n = 0;
      while (done_n < PHASE_BYTES) begin
        w.start_of_image = img_done ? ($urandom_range(0, 3) != 0)
                                    : ($urandom_range(0, 39) == 0);
        header_next = cfg_now.rle_mode && (w.start_of_image || pk_left == '0);
        if (header_next && $urandom_range(0, 9) != 0) begin
          sel = $urandom_range(0, 9);
          cnt = (sel < 7) ? 7'($urandom_range(0, 7)) :
                (sel < 9) ? 7'($urandom_range(8, 63)) : 7'($urandom_range(64, 127));
          w.data_byte = {1'($urandom_range(0, 1)), cnt};
        end else begin
          w.data_byte = 8'($urandom_range(0, 255));
        end
        feed_byte(w, 1'b0, NO_SEG, taken);
        if (taken) done_n++;
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_segs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
